FILE: rtl/core/scfp_pkg.sv
// shared types, constants and helper functions of the sine/cosine generator
`timescale 1ns / 1ps
`default_nettype none

package scfp_pkg;

  // field widths
  localparam int ANGLE_W       = 16;
  localparam int OUT_W         = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 2 * OUT_W;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_POLY_ORDER = 1'b0;
  localparam logic POLY_ORDER_RST = 1'b1;

  // internal widths
  localparam int X_W     = 16;
  localparam int X2_W    = 29;
  localparam int K4_W    = 30;
  localparam int K_W     = 31;
  localparam int M1_W    = K4_W + X2_W;
  localparam int SUB_W   = K_W + X2_W;
  localparam int C60_W   = 61;
  localparam int C31_W   = 32;
  localparam int SQ_W    = 63;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = ROOT_W + 3;

  // square root pipeline: two root bits a stage
  localparam int SQRT_BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_BITS_PER_STAGE - 1) / SQRT_BITS_PER_STAGE;

  // polynomial coefficients, scaled to 2^-60 (K4 to 2^-92)
  localparam logic [K_W-1:0]  K2 = 31'd1257966796;
  localparam logic [K_W-1:0]  K1 = 31'd1324136962;
  localparam logic [K4_W-1:0] K4 = 30'd1058722661;

  localparam logic [C60_W-1:0] ONE_Q60 = C60_W'(1) << 60;
  localparam logic [C60_W-1:0] HALF_Q29 = C60_W'(1) << 28;
  localparam logic [SQ_W-1:0]  ONE_Q62 = SQ_W'(1) << 62;

  localparam int SAT_MAX = (1 << (OUT_W - 1)) - 1;

  // flags that follow an angle through folding and polynomial
  typedef struct packed {
    logic fourth;
    logic f14;
    logic a15;
    logic f15;
  } flags_t;

  // flags plus finished cosine magnitude, carried alongside the root
  typedef struct packed {
    logic [OUT_W-1:0] cmag;
    logic             f14;
    logic             a15;
    logic             f15;
  } side_t;

  // round half up from q.31 to the output fraction, saturate at +1.0 - lsb
  function automatic logic [OUT_W-1:0] to_out_mag(input logic [C31_W-1:0] q);
    logic [C31_W:0] sum;
    logic [C31_W:0] sh;
    sum = {1'b0, q} + ((C31_W + 1)'(1) << (30 - OUT_FRAC_BITS));
    sh  = sum >> (31 - OUT_FRAC_BITS);
    if (sh > (C31_W + 1)'(SAT_MAX)) begin
      return OUT_W'(SAT_MAX);
    end
    return sh[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scfp_fold.sv
// octant folding of the angle and squaring of the reduced argument
`timescale 1ns / 1ps
`default_nettype none

module scfp_fold (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [scfp_pkg::ANGLE_W-1:0] angle,
  input  logic                                poly_order,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [scfp_pkg::X2_W-1:0]           x2,
  output scfp_pkg::flags_t                    flags
);
  import scfp_pkg::*;

  logic [ANGLE_W-1:0]    a;
  logic                  f14;
  logic                  f15;
  logic [14:0]           low_nxt;
  logic signed [X_W-1:0] x_nxt;
  flags_t                fl_nxt;
  logic signed [2*X_W-1:0] prod_nxt;

  logic                  v1_r;
  logic signed [X_W-1:0] x_r;
  flags_t                fl1_r;
  logic                  v2_r;
  logic [X2_W-1:0]       x2_r;
  flags_t                fl2_r;
  logic                  rdy1;
  logic                  rdy2;

  assign a       = angle;
  assign f14     = a[14] ^ a[13];
  assign f15     = a[15] ^ a[14];
  assign low_nxt = a[14:0] + {f14, 14'b0};
  // twice the sign-extended 15-bit value
  assign x_nxt   = {low_nxt, 1'b0};
  assign fl_nxt  = '{fourth: poly_order, f14: f14, a15: a[15], f15: f15};
  assign prod_nxt = x_r * x_r;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x_r   <= x_nxt;
      fl1_r <= fl_nxt;
    end
    if (rdy2 && v1_r) begin
      x2_r  <= prod_nxt[X2_W-1:0];
      fl2_r <= fl1_r;
    end
  end

  assign out_valid = v2_r;
  assign x2        = x2_r;
  assign flags     = fl2_r;

endmodule

`default_nettype wire

FILE: rtl/core/scfp_poly.sv
// cosine polynomial, q.31 rounding and square-root radicand
`timescale 1ns / 1ps
`default_nettype none

module scfp_poly (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scfp_pkg::X2_W-1:0]   x2,
  input  scfp_pkg::flags_t            flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scfp_pkg::RAD_W-1:0]  rad,
  output scfp_pkg::side_t             side
);
  import scfp_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST:0]   rdy;
  logic [NST-1:0] ld;

  // stage 1: K4 * x2
  logic [M1_W-1:0]  m1_nxt;
  logic [M1_W-1:0]  m1_r;
  logic [X2_W-1:0]  x2a_r;
  flags_t           fla_r;
  // stage 2: inner coefficient
  logic [K_W-1:0]   t_nxt;
  logic [K_W-1:0]   t_r;
  logic [X2_W-1:0]  x2b_r;
  flags_t           flb_r;
  // stage 3: t * x2
  logic [SUB_W-1:0] sub_nxt;
  logic [SUB_W-1:0] sub_r;
  flags_t           flc_r;
  // stage 4: cosine in q.31
  logic [C60_W-1:0] c60;
  logic [C60_W-1:0] c_rnd;
  logic [C31_W-1:0] c31_r;
  flags_t           fld_r;
  // stage 5: square of cosine
  logic [2*C31_W-1:0] sq_nxt;
  logic [SQ_W-1:0]  sq_r;
  side_t            side_nxt;
  side_t            sde_r;
  // stage 6: radicand
  logic [SQ_W-1:0]  diff;
  logic [RAD_W-1:0] rad_nxt;
  logic [RAD_W-1:0] rad_r;
  side_t            sdf_r;

  assign v_in = {v_r[NST-2:0], in_valid};

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign ld       = rdy[NST-1:0] & v_in;
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  assign m1_nxt  = K4 * x2;
  assign t_nxt   = fla_r.fourth ? (K1 - K_W'(m1_r[M1_W-1:32])) : K2;
  assign sub_nxt = t_r * x2b_r;
  assign c60     = ONE_Q60 - C60_W'(sub_r);
  assign c_rnd   = c60 + HALF_Q29;
  assign sq_nxt  = c31_r * c31_r;
  assign side_nxt = '{cmag: to_out_mag(c31_r), f14: fld_r.f14, a15: fld_r.a15,
                      f15: fld_r.f15};
  assign diff    = ONE_Q62 - sq_r;
  // radicand clamped at zero when the cosine is exactly one
  assign rad_nxt = sq_r[SQ_W-1] ? '0 : diff[RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m1_r  <= m1_nxt;
      x2a_r <= x2;
      fla_r <= flags;
    end
    if (ld[1]) begin
      t_r   <= t_nxt;
      x2b_r <= x2a_r;
      flb_r <= fla_r;
    end
    if (ld[2]) begin
      sub_r <= sub_nxt;
      flc_r <= flb_r;
    end
    if (ld[3]) begin
      c31_r <= c_rnd[C60_W-1:29];
      fld_r <= flc_r;
    end
    if (ld[4]) begin
      sq_r  <= sq_nxt[SQ_W-1:0];
      sde_r <= side_nxt;
    end
    if (ld[5]) begin
      rad_r <= rad_nxt;
      sdf_r <= sde_r;
    end
  end

  assign out_valid = v_r[NST-1];
  assign rad       = rad_r;
  assign side      = sdf_r;

endmodule

`default_nettype wire

FILE: rtl/core/scfp_sqrt.sv
// pipelined digit-by-digit integer square root, two root bits a stage
`timescale 1ns / 1ps
`default_nettype none

module scfp_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scfp_pkg::RAD_W-1:0]  rad,
  input  scfp_pkg::side_t             side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scfp_pkg::ROOT_W-1:0] root,
  output scfp_pkg::side_t             side_out
);
  import scfp_pkg::*;

  logic [SQRT_STAGES-1:0] v_r;
  logic [SQRT_STAGES-1:0] v_in;
  logic [SQRT_STAGES:0]   rdy;

  logic [RAD_W-1:0]  rad_r  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] q_r    [SQRT_STAGES];
  side_t             side_r [SQRT_STAGES];

  assign v_in = {v_r[SQRT_STAGES-2:0], in_valid};

  always_comb begin
    rdy[SQRT_STAGES] = out_ready;
    for (int k = SQRT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] q_i;
    side_t             side_i;
    logic [RAD_W-1:0]  rad_nxt;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign q_i    = '0;
      assign side_i = side;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign q_i    = q_r[k-1];
      assign side_i = side_r[k-1];
    end

    always_comb begin
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      rad_nxt = rad_i;
      rem_nxt = rem_i;
      q_nxt   = q_i;
      for (int j = 0; j < SQRT_BITS_PER_STAGE; j++) begin
        if (k * SQRT_BITS_PER_STAGE + j < ROOT_W) begin
          // bring down the next two radicand bits and try a one digit
          rem2    = {rem_nxt[REM_W-3:0], rad_nxt[RAD_W-1 -: 2]};
          rad_nxt = rad_nxt << 2;
          trial   = {1'b0, q_nxt, 2'b01};
          if (rem2 >= trial) begin
            rem_nxt = rem2 - trial;
            q_nxt   = {q_nxt[ROOT_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem2;
            q_nxt   = {q_nxt[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in[k]) begin
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign root      = q_r[SQRT_STAGES-1];
  assign side_out  = side_r[SQRT_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/scfp_out.sv
// sine rounding, octant swap and sign, output register
`timescale 1ns / 1ps
`default_nettype none

module scfp_out (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [scfp_pkg::ROOT_W-1:0]     root,
  input  scfp_pkg::side_t                 side,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [scfp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import scfp_pkg::*;

  logic [OUT_W-1:0]      smag;
  logic [OUT_W-1:0]      s_sel;
  logic [OUT_W-1:0]      c_sel;
  logic [OUT_W-1:0]      sine_nxt;
  logic [OUT_W-1:0]      cosine_nxt;
  logic                  v_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  rdy;

  assign smag       = to_out_mag({{(C31_W - ROOT_W){1'b0}}, root});
  assign s_sel      = side.f14 ? side.cmag : smag;
  assign c_sel      = side.f14 ? smag : side.cmag;
  assign sine_nxt   = side.a15 ? (OUT_W'(0) - s_sel) : s_sel;
  assign cosine_nxt = side.f15 ? (OUT_W'(0) - c_sel) : c_sel;

  assign rdy      = !v_r || out_tready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      data_r <= {cosine_nxt, sine_nxt};
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/sincos_folded_polynomial_top.sv
// top level of the octant-folded polynomial sine/cosine generator
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tdata[15:0] angle (65536 per turn)
//  out_    | master    | out_tvalid / out_tready| out_tdata[15:0] sine, [31:16] cosine
//  cfg_    | apb slave | psel/penable/pready    | reg 0 @0x0: poly_order (bit 0)
//
// one angle a cycle while out_tready holds; a beat passes through folding and squaring,
// the cosine polynomial and radicand, the root pipeline and 1 output register
// the root pipeline's two bits a stage sets the depth
// rst_n is synchronous, clears all valid bits and sets poly_order to fourth order
// every stage holds its beat while the next one is full and cannot move on; bubbles close up,
// so a beat can be accepted while a finished result waits at the output, if a stage is empty
`timescale 1ns / 1ps
`default_nettype none

module sincos_folded_polynomial_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [scfp_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] angle
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [scfp_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] sine, [31:16] cosine
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [scfp_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [scfp_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [scfp_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import scfp_pkg::*;

  logic poly_order_r;
  logic cfg_wr;

  logic            fold_valid;
  logic            fold_ready;
  logic [X2_W-1:0] fold_x2;
  flags_t          fold_flags;

  logic             poly_valid;
  logic             poly_ready;
  logic [RAD_W-1:0] poly_rad;
  side_t            poly_side;

  logic              sqrt_valid;
  logic              sqrt_ready;
  logic [ROOT_W-1:0] sqrt_root;
  side_t             sqrt_side;

  // apb register; only paddr bit 2 picks the register, low bits ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_POLY_ORDER);
  assign cfg_prdata = (cfg_paddr[2] == REG_POLY_ORDER) ? {{(CFG_DW - 1){1'b0}}, poly_order_r}
                                                       : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r <= POLY_ORDER_RST;
    end else if (cfg_wr) begin
      poly_order_r <= cfg_pwdata[0];
    end
  end

  // fold into the octant around zero, square the reduced argument
  scfp_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .angle      (in_tdata[ANGLE_W-1:0]),
    .poly_order (poly_order_r),
    .out_valid  (fold_valid),
    .out_ready  (fold_ready),
    .x2         (fold_x2),
    .flags      (fold_flags)
  );

  // cosine polynomial and 1 - cos^2
  scfp_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .x2        (fold_x2),
    .flags     (fold_flags),
    .out_valid (poly_valid),
    .out_ready (poly_ready),
    .rad       (poly_rad),
    .side      (poly_side)
  );

  // sine magnitude as integer root of the radicand
  scfp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (poly_valid),
    .in_ready  (poly_ready),
    .rad       (poly_rad),
    .side      (poly_side),
    .out_valid (sqrt_valid),
    .out_ready (sqrt_ready),
    .root      (sqrt_root),
    .side_out  (sqrt_side)
  );

  // map back to the true octant and hold the result beat
  scfp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sqrt_valid),
    .in_ready   (sqrt_ready),
    .root       (sqrt_root),
    .side       (sqrt_side),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/scfp_checker.sv
// port-level assertions for the sine/cosine generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module scfp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [scfp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [scfp_pkg::CFG_AW-1:0]     cfg_paddr,
  input logic [scfp_pkg::CFG_DW-1:0]     cfg_pwdata,
  input logic [scfp_pkg::CFG_DW-1:0]     cfg_prdata,
  input logic                            cfg_pready
);
  import scfp_pkg::*;

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // magnitudes saturate, so full-scale negative never appears
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_W-1:0] != 16'h8000)
                   && (out_tdata[OUT_DATA_W-1:OUT_W] != 16'h8000))
    else $error("output reached -1.0");

  // an empty output stage means the pipeline can take a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // poly_order reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
    && (cfg_paddr[2] == REG_POLY_ORDER) && !in_beat
    |=> cfg_prdata[0] == $past(cfg_pwdata[0]) || cfg_paddr[2] != REG_POLY_ORDER)
    else $error("poly_order readback mismatch");

endmodule

bind sincos_folded_polynomial_top scfp_checker u_scfp_checker (.*);

`default_nettype wire
